@@ hw/rtl/qgi_pkg.sv @@
package qgi_pkg;

    // field widths
    localparam int QUAT_FRAC_BITS_DEF = 29;
    localparam int QUAT_W             = 32;
    localparam int RATE_W             = 24;
    localparam int DT_W               = 24;
    localparam int NORM_FLOOR_W       = 30;
    localparam logic [NORM_FLOOR_W-1:0] NORM_FLOOR_RST = 30'd537;
    localparam int S_TDATA_W          = 96;
    localparam int M_TDATA_W          = 128;

    // multiplier op schedule: 12 mac terms, 8 scale halves, 4 squares
    localparam int MUL_IDX_W      = 5;
    localparam int MUL_SCALE_BASE = 12;
    localparam int MUL_SQ_BASE    = 20;
    localparam int MUL_OPS        = 24;

    // quaternion component codes
    localparam logic [1:0] QC_W = 2'd0;
    localparam logic [1:0] QC_X = 2'd1;
    localparam logic [1:0] QC_Y = 2'd2;
    localparam logic [1:0] QC_Z = 2'd3;

    // rate axis codes
    localparam logic [1:0] RS_X = 2'd0;
    localparam logic [1:0] RS_Y = 2'd1;
    localparam logic [1:0] RS_Z = 2'd2;

    typedef struct packed {
        logic [1:0] qsel;
        logic [1:0] rsel;
        logic       neg;
        logic       last;
        logic [1:0] comp;
    } mac_op_t;

    typedef struct packed {
        logic                 start;
        logic                 mul_go;
        logic [MUL_IDX_W-1:0] mul_idx;
        logic                 sq_init;
        logic                 sq_step;
        logic                 chk;
        logic                 div_init;
        logic                 div_step;
        logic                 div_wr;
        logic [1:0]           comp;
        logic                 out_load;
    } qgi_cmd_t;

    typedef struct packed {
        logic degen;
    } qgi_stat_t;

    // terms of the quaternion product q (x) omega, three per component
    function automatic mac_op_t mac_op(input logic [3:0] idx);
        mac_op_t op;
        op = '0;
        unique case (idx)
            4'd0:    op = '{qsel: QC_X, rsel: RS_X, neg: 1'b1, last: 1'b0, comp: QC_W};
            4'd1:    op = '{qsel: QC_Y, rsel: RS_Y, neg: 1'b1, last: 1'b0, comp: QC_W};
            4'd2:    op = '{qsel: QC_Z, rsel: RS_Z, neg: 1'b1, last: 1'b1, comp: QC_W};
            4'd3:    op = '{qsel: QC_W, rsel: RS_X, neg: 1'b0, last: 1'b0, comp: QC_X};
            4'd4:    op = '{qsel: QC_Y, rsel: RS_Z, neg: 1'b0, last: 1'b0, comp: QC_X};
            4'd5:    op = '{qsel: QC_Z, rsel: RS_Y, neg: 1'b1, last: 1'b1, comp: QC_X};
            4'd6:    op = '{qsel: QC_W, rsel: RS_Y, neg: 1'b0, last: 1'b0, comp: QC_Y};
            4'd7:    op = '{qsel: QC_X, rsel: RS_Z, neg: 1'b1, last: 1'b0, comp: QC_Y};
            4'd8:    op = '{qsel: QC_Z, rsel: RS_X, neg: 1'b0, last: 1'b1, comp: QC_Y};
            4'd9:    op = '{qsel: QC_W, rsel: RS_Z, neg: 1'b0, last: 1'b0, comp: QC_Z};
            4'd10:   op = '{qsel: QC_X, rsel: RS_Y, neg: 1'b0, last: 1'b0, comp: QC_Z};
            4'd11:   op = '{qsel: QC_Y, rsel: RS_X, neg: 1'b1, last: 1'b1, comp: QC_Z};
            default: op = '0;
        endcase
        return op;
    endfunction

endpackage

@@ hw/rtl/quaternion_gyro_integrator.sv @@
// Attitude quaternion integrator for gyro samples.
// Input stream (s_*): one transfer per sample, carrying three body rates
// (2^-16 rad/s) and the interval (2^-24 s). The block adds the first-order
// derivative to its stored Q2.29 quaternion, saturates, and renormalizes.
// Output stream (m_*): one transfer per input, the new quaternion in tdata
// and a flag in tuser that is set when the norm fell under norm_floor and
// the state went back to identity.
// cfg_wr_en/cfg_wr_data write norm_floor; write only while the block is idle.
// Flow: one item is handled at a time. From accept to result, a normal item
// makes 24 passes through one shared 33x33 multiplier, a 33-step square
// root, and four restoring divisions of F+2 steps each. An item that hits
// the floor skips the divisions.
// s_tready is high only while idle and out of reset. The result sits in an
// output register; if the receiver stalls, the finished item waits there,
// the following item is still accepted and computed but holds in its last
// step until the register frees up, and no further item is accepted before.
// Reset: state returns to identity, norm_floor to 537, no result pending.
module quaternion_gyro_integrator #(
    parameter int QUAT_FRAC_BITS = qgi_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [qgi_pkg::NORM_FLOOR_W-1:0] cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rate_x, rate_y, rate_z, step_time
    input  logic [qgi_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [qgi_pkg::M_TDATA_W-1:0]    m_tdata,
    // degenerate
    output logic [0:0]                       m_tuser
);
    import qgi_pkg::*;

    qgi_cmd_t  cmd;
    qgi_stat_t stat;

    qgi_ctrl #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    qgi_datapath #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

@@ hw/rtl/qgi_datapath.sv @@
module qgi_datapath #(
    parameter int QUAT_FRAC_BITS = qgi_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [qgi_pkg::NORM_FLOOR_W-1:0]  cfg_wr_data,
    input  logic [qgi_pkg::S_TDATA_W-1:0]     s_tdata,
    input  qgi_pkg::qgi_cmd_t                 cmd,
    output qgi_pkg::qgi_stat_t                stat,
    output logic [qgi_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [0:0]                        m_tuser
);
    import qgi_pkg::*;

    localparam int QB   = QUAT_FRAC_BITS + 2;   // quotient bits
    localparam int DW   = QUAT_FRAC_BITS + 33;  // dividend bits
    localparam logic [31:0] IDENT = 32'd1 << QUAT_FRAC_BITS;
    localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
    localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

    // configuration and latched input
    logic [NORM_FLOOR_W-1:0] floor_reg;
    logic signed [23:0]      rx_reg, ry_reg, rz_reg;
    logic [23:0]             dt_reg;

    // attitude state and accumulators
    logic signed [31:0] att_reg [4];
    logic signed [57:0] acc_reg;
    logic signed [57:0] sum_reg [4];
    logic [64:0]        sumsq_reg;

    // multiplier pipeline
    logic signed [65:0] prod_reg;
    logic               opd_go_reg;
    logic [4:0]         opd_idx_reg;
    logic signed [31:0] opd_q_reg;
    logic               opd_sgn_reg;
    logic [56:0]        lo_reg;
    logic signed [41:0] delta_reg;
    logic               upd_go_reg;
    logic [1:0]         upd_c_reg;
    logic signed [31:0] upd_q_reg;

    // square root and divider
    logic [65:0]        sq_sh_reg;
    logic [34:0]        sq_rem_reg;
    logic [32:0]        root_reg;
    logic               degen_reg;
    logic [32:0]        dv_rem_reg;
    logic [QB-1:0]      dv_low_reg;
    logic [QB-1:0]      dv_quot_reg;
    logic               dv_neg_reg;

    // output register
    logic [31:0]        out_q_reg [4];
    logic               out_degen_reg;

    // issue stage decode
    mac_op_t            iop;
    logic [4:0]         scale_off;
    logic [4:0]         sq_off;
    logic               is_mac, is_scale;
    logic [1:0]         rd_addr;
    logic signed [31:0] att_rd;
    logic signed [57:0] sum_sel;
    logic [57:0]        mag;
    logic signed [23:0] rate_sel;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_next;

    assign iop       = mac_op(cmd.mul_idx[3:0]);
    assign scale_off = cmd.mul_idx - 5'(MUL_SCALE_BASE);
    assign sq_off    = cmd.mul_idx - 5'(MUL_SQ_BASE);
    assign is_mac    = cmd.mul_idx < 5'(MUL_SCALE_BASE);
    assign is_scale  = !is_mac && (cmd.mul_idx < 5'(MUL_SQ_BASE));

    // single read port on the attitude registers for the multiplier and divider
    always_comb begin
        if (cmd.div_init) begin
            rd_addr = cmd.comp;
        end else if (is_mac) begin
            rd_addr = iop.qsel;
        end else if (is_scale) begin
            rd_addr = scale_off[2:1];
        end else begin
            rd_addr = sq_off[1:0];
        end
    end
    assign att_rd  = att_reg[rd_addr];
    assign sum_sel = sum_reg[scale_off[2:1]];
    assign mag     = sum_sel[57] ? 58'(-sum_sel) : 58'(sum_sel);

    always_comb begin
        case (iop.rsel)
            RS_X:    rate_sel = rx_reg;
            RS_Y:    rate_sel = ry_reg;
            default: rate_sel = rz_reg;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        if (is_mac) begin
            mul_a = {att_rd[31], att_rd};
            mul_b = {{9{rate_sel[23]}}, rate_sel};
        end else if (is_scale) begin
            mul_a = scale_off[0] ? $signed({7'd0, mag[57:32]}) : $signed({1'b0, mag[31:0]});
            mul_b = $signed({9'd0, dt_reg});
        end else begin
            mul_a = {att_rd[31], att_rd};
            mul_b = {att_rd[31], att_rd};
        end
    end
    assign prod_next = mul_a * mul_b;

    // accumulate stage decode
    mac_op_t            aop;
    logic [4:0]         a_scale_off;
    logic               a_mac, a_scale;
    logic signed [57:0] pterm, term, acc_sum;
    logic [80:0]        wide;
    logic [39:0]        rnd;
    logic signed [41:0] rnd_s;

    assign aop         = mac_op(opd_idx_reg[3:0]);
    assign a_scale_off = opd_idx_reg - 5'(MUL_SCALE_BASE);
    assign a_mac       = opd_idx_reg < 5'(MUL_SCALE_BASE);
    assign a_scale     = !a_mac && (opd_idx_reg < 5'(MUL_SQ_BASE));
    assign pterm       = prod_reg[57:0];
    assign term        = aop.neg ? -pterm : pterm;
    assign acc_sum     = acc_reg + term;
    assign wide        = {prod_reg[48:0], 32'd0} + 81'(lo_reg);
    assign rnd         = wide[80:41];
    assign rnd_s       = $signed({2'b00, rnd});

    // saturating component update
    logic signed [41:0] upd_sum;
    logic signed [31:0] upd_sat;
    assign upd_sum = $signed({{10{upd_q_reg[31]}}, upd_q_reg}) + delta_reg;
    always_comb begin
        if (upd_sum > SAT_HI) begin
            upd_sat = 32'sh7FFFFFFF;
        end else if (upd_sum < SAT_LO) begin
            upd_sat = 32'sh80000000;
        end else begin
            upd_sat = upd_sum[31:0];
        end
    end

    // square root step, two radicand bits at a time
    logic [36:0] sq_r, sq_trial, sq_diff;
    logic        sq_ge;
    assign sq_r     = {sq_rem_reg, sq_sh_reg[65:64]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_r >= sq_trial;
    assign sq_diff  = sq_r - sq_trial;

    // floor test
    logic degen_now;
    assign degen_now  = (root_reg == 33'd0) || (root_reg < {3'd0, floor_reg});
    assign stat.degen = degen_now;

    // divider init and step
    logic [31:0]   dv_mag;
    logic [DW-1:0] dv_d;
    logic [33:0]   dv_r2, dv_diff;
    logic          dv_ge;
    logic [31:0]   dv_qv;
    assign dv_mag  = att_rd[31] ? 32'(-att_rd) : 32'(att_rd);
    assign dv_d    = (DW'(dv_mag) << QUAT_FRAC_BITS) + DW'(root_reg >> 1);
    assign dv_r2   = {dv_rem_reg, dv_low_reg[QB-1]};
    assign dv_ge   = dv_r2 >= {1'b0, root_reg};
    assign dv_diff = dv_r2 - {1'b0, root_reg};
    assign dv_qv   = 32'(dv_quot_reg);

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= NORM_FLOOR_RST;
        end else if (cfg_wr_en) begin
            floor_reg <= cfg_wr_data;
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opd_go_reg <= 1'b0;
            upd_go_reg <= 1'b0;
        end else begin
            opd_go_reg <= cmd.mul_go;
            upd_go_reg <= opd_go_reg && a_scale && a_scale_off[0];
        end
    end

    // attitude state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            att_reg[0] <= IDENT;
            att_reg[1] <= '0;
            att_reg[2] <= '0;
            att_reg[3] <= '0;
        end else if (upd_go_reg) begin
            att_reg[upd_c_reg] <= upd_sat;
        end else if (cmd.chk && degen_now) begin
            att_reg[0] <= IDENT;
            att_reg[1] <= '0;
            att_reg[2] <= '0;
            att_reg[3] <= '0;
        end else if (cmd.div_wr) begin
            att_reg[cmd.comp] <= dv_neg_reg ? -$signed(dv_qv) : $signed(dv_qv);
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rx_reg    <= s_tdata[23:0];
            ry_reg    <= s_tdata[47:24];
            rz_reg    <= s_tdata[71:48];
            dt_reg    <= s_tdata[95:72];
            acc_reg   <= '0;
            sumsq_reg <= '0;
        end
        // issue
        prod_reg    <= prod_next;
        opd_idx_reg <= cmd.mul_idx;
        opd_q_reg   <= att_rd;
        opd_sgn_reg <= sum_sel[57];
        // accumulate
        if (opd_go_reg) begin
            if (a_mac) begin
                if (aop.last) begin
                    sum_reg[aop.comp] <= acc_sum;
                    acc_reg           <= '0;
                end else begin
                    acc_reg <= acc_sum;
                end
            end else if (a_scale) begin
                if (!a_scale_off[0]) begin
                    lo_reg <= 57'(prod_reg[55:0]) + (57'd1 << 40);
                end else begin
                    delta_reg <= opd_sgn_reg ? -rnd_s : rnd_s;
                    upd_c_reg <= a_scale_off[2:1];
                    upd_q_reg <= opd_q_reg;
                end
            end else begin
                sumsq_reg <= sumsq_reg + {1'b0, prod_reg[63:0]};
            end
        end
        // square root
        if (cmd.sq_init) begin
            sq_sh_reg  <= {1'b0, sumsq_reg};
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end else if (cmd.sq_step) begin
            sq_sh_reg  <= {sq_sh_reg[63:0], 2'b00};
            sq_rem_reg <= sq_ge ? sq_diff[34:0] : sq_r[34:0];
            root_reg   <= {root_reg[31:0], sq_ge};
        end
        if (cmd.chk) begin
            degen_reg <= degen_now;
        end
        // divider
        if (cmd.div_init) begin
            dv_rem_reg  <= 33'(dv_d[DW-1:QB]);
            dv_low_reg  <= dv_d[QB-1:0];
            dv_quot_reg <= '0;
            dv_neg_reg  <= att_rd[31];
        end else if (cmd.div_step) begin
            dv_rem_reg  <= dv_ge ? dv_diff[32:0] : dv_r2[32:0];
            dv_low_reg  <= {dv_low_reg[QB-2:0], 1'b0};
            dv_quot_reg <= {dv_quot_reg[QB-2:0], dv_ge};
        end
        // result register
        if (cmd.out_load) begin
            out_q_reg[0]  <= att_reg[0];
            out_q_reg[1]  <= att_reg[1];
            out_q_reg[2]  <= att_reg[2];
            out_q_reg[3]  <= att_reg[3];
            out_degen_reg <= degen_reg;
        end
    end

    assign m_tdata = {out_q_reg[3], out_q_reg[2], out_q_reg[1], out_q_reg[0]};
    assign m_tuser = out_degen_reg;

endmodule

@@ hw/rtl/qgi_ctrl.sv @@
module qgi_ctrl #(
    parameter int QUAT_FRAC_BITS = qgi_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output qgi_pkg::qgi_cmd_t  cmd,
    input  qgi_pkg::qgi_stat_t stat
);
    import qgi_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_SQI  = 4'd2;
    localparam logic [3:0] ST_SQRT = 4'd3;
    localparam logic [3:0] ST_CHK  = 4'd4;
    localparam logic [3:0] ST_DIVI = 4'd5;
    localparam logic [3:0] ST_DIVS = 4'd6;
    localparam logic [3:0] ST_DIVW = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    // the multiply phase runs on past the last op to drain the multiply and update stages
    localparam logic [5:0] MUL_LAST  = 6'(MUL_OPS + 1);
    localparam logic [5:0] SQRT_LAST = 6'd32;
    localparam logic [5:0] DIV_LAST  = 6'(QUAT_FRAC_BITS + 1);

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic       m_tvalid_reg;

    assign s_tready = (state_reg == ST_IDLE) && aresetn;
    assign m_tvalid = m_tvalid_reg;

    // sequencer
    always_comb begin
        cmd        = '0;
        cmd.comp   = comp_reg;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_go  = cnt_reg < 6'(MUL_OPS);
                cmd.mul_idx = cnt_reg[MUL_IDX_W-1:0];
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_SQI;
                end
            end
            ST_SQI: begin
                cmd.sq_init = 1'b1;
                cnt_next    = '0;
                state_next  = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                cmd.chk   = 1'b1;
                comp_next = QC_W;
                if (stat.degen) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIVI;
                end
            end
            ST_DIVI: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVS;
            end
            ST_DIVS: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW: begin
                cmd.div_wr = 1'b1;
                if (comp_reg == QC_Z) begin
                    state_next = ST_DONE;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_DIVI;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            comp_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending transfer");
    a_accept_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL))
        else $error("accepted item did not start multiply phase");
    a_chk_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK && !stat.degen) |=> (state_reg == ST_DIVI && comp_reg == QC_W))
        else $error("normalization did not start at first component");
    a_sqrt_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> (cnt_reg <= SQRT_LAST))
        else $error("square root step count overrun");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

import qgi_pkg::*;

// attitude tracker: predicts each result and checks transfers in order
class attitude_tracker;
    logic signed [31:0] aw, ax, ay, az;
    logic [29:0]        floor_lvl;
    logic [128:0]       pending[$];
    int                 mismatches;
    int                 frac;

    function new(int f);
        frac = f;
        mismatches = 0;
        reset_state();
        floor_lvl = NORM_FLOOR_RST;
    endfunction

    function void reset_state();
        aw = 32'sd1 <<< frac;
        ax = 0;
        ay = 0;
        az = 0;
    endfunction

    function void set_floor(logic [29:0] v);
        floor_lvl = v;
    endfunction

    static function logic signed [31:0] clamp(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // round(sum * dt / 2^41), half away from zero
    static function logic signed [63:0] delta(logic signed [63:0] sum, logic [23:0] dt);
        logic [127:0] m;
        logic [127:0] r;
        m = (sum < 0) ? -sum : sum;
        r = (m * dt + (128'd1 << 40)) >> 41;
        return (sum < 0) ? -$signed(r[63:0]) : $signed(r[63:0]);
    endfunction

    static function logic [63:0] root(logic [65:0] v);
        logic [65:0] lo, hi, mid;
        lo = 0;
        hi = 66'd1 << 33;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo[63:0];
    endfunction

    function logic signed [31:0] unitize(logic signed [31:0] q, logic [63:0] n);
        logic [95:0] m;
        logic [95:0] r;
        m = (q < 0) ? -$signed({{64{q[31]}}, q}) : {64'd0, q};
        r = ((m << frac) + (n >> 1)) / n;
        return clamp((q < 0) ? -$signed(r[63:0]) : $signed(r[63:0]));
    endfunction

    // advance the attitude by one gyro sample
    function void note_sample(logic [95:0] d);
        logic signed [63:0] gx, gy, gz, w, x, y, z;
        logic signed [31:0] nw, nx, ny, nz;
        logic [65:0]        ss;
        logic [63:0]        n;
        logic [23:0]        dt;
        logic               degen;
        gx = $signed(d[23:0]);
        gy = $signed(d[47:24]);
        gz = $signed(d[71:48]);
        dt = d[95:72];
        w = aw; x = ax; y = ay; z = az;
        nw = clamp(w + delta(-x * gx - y * gy - z * gz, dt));
        nx = clamp(x + delta(w * gx + y * gz - z * gy, dt));
        ny = clamp(y + delta(w * gy - x * gz + z * gx, dt));
        nz = clamp(z + delta(w * gz + x * gy - y * gx, dt));
        ss = 66'(64'(nw) * 64'(nw)) + 66'(64'(nx) * 64'(nx))
           + 66'(64'(ny) * 64'(ny)) + 66'(64'(nz) * 64'(nz));
        n = (ss >= (66'd1 << 64)) ? (64'd1 << 32) : root(ss);
        degen = (n == 0) || (n < floor_lvl);
        if (degen) begin
            reset_state();
        end else begin
            aw = unitize(nw, n);
            ax = unitize(nx, n);
            ay = unitize(ny, n);
            az = unitize(nz, n);
        end
        pending.push_back({degen, az, ay, ax, aw});
    endfunction

    function void check_result(logic [127:0] d, logic u);
        logic [128:0] e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", d);
            return;
        end
        e = pending.pop_front();
        for (int i = 0; i < 4; i++) begin
            if (e[32*i +: 32] !== d[32*i +: 32]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("quat[%0d]: expected %h, got %h", i, e[32*i +: 32], d[32*i +: 32]);
            end
        end
        if (e[128] !== u) begin
            mismatches++;
            if (mismatches <= 10) $display("degenerate: expected %b, got %b", e[128], u);
        end
    endfunction
endclass

module tb;
    localparam int FRAC = QUAT_FRAC_BITS_DEF;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [NORM_FLOOR_W-1:0] cfg_wr_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [0:0]              m_tuser;

    attitude_tracker tracker = new(FRAC);
    bit               sending_done = 0;

    always #5 aclk = ~aclk;

    quaternion_gyro_integrator #(.QUAT_FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    // input transfers are predicted and output transfers checked at the transfer edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) tracker.note_sample(s_tdata);
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser[0]);
    end

    // receiver stalls
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge aclk);
        end
    end

    // tvalid stays up after a transfer until the next gap or the next item
    task automatic send_sample(logic [23:0] rx, ry, rz, dt);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata <= {dt, rz, ry, rx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(negedge aclk);
        repeat (250) @(negedge aclk);
    endtask

    task automatic write_floor(logic [29:0] v);
        drain();
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_floor(v);
    endtask

    function automatic logic [23:0] rand_rate();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [23:0] rand_dt();
        case ($urandom_range(0, 4))
            0: return 24'hffffff;
            1: return 24'd0;
            2: return 24'($urandom_range(0, 20000));
            default: return 24'($urandom());
        endcase
    endfunction

    initial begin
        logic [29:0] floors[4];
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero step, extremes of each rate and the interval
        send_sample(24'd0, 24'd0, 24'd0, 24'd0);
        send_sample(24'h7fffff, 24'd0, 24'd0, 24'hffffff);
        send_sample(24'd0, 24'h800000, 24'd0, 24'hffffff);
        send_sample(24'd0, 24'd0, 24'h7fffff, 24'hffffff);
        send_sample(24'h800000, 24'h800000, 24'h800000, 24'hffffff);
        send_sample(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'hffffff);
        send_sample(24'h000001, 24'hffffff, 24'h000001, 24'd1);
        send_sample(24'h555555, 24'haaaaaa, 24'h123456, 24'h800000);
        // floor at unit norm: any norm below one resets to identity
        write_floor(30'h20000000);
        send_sample(24'd0, 24'd0, 24'd0, 24'd0);
        send_sample(24'h7fffff, 24'd0, 24'd0, 24'hffffff);
        // floor zero: nothing is degenerate unless the norm is zero
        write_floor(30'd0);
        send_sample(24'h800000, 24'h7fffff, 24'h800000, 24'hffffff);
        send_sample(24'h3fffff, 24'hc00000, 24'h7fffff, 24'hffffff);
        write_floor(30'h3fffffff);
        send_sample(24'h000010, 24'h000020, 24'h000030, 24'h000100);

        floors[0] = 30'd537;
        floors[1] = 30'h1fffffff;
        floors[2] = 30'h20000000;
        floors[3] = 30'd0;
        for (int ph = 0; ph < 7; ph++) begin
            write_floor((ph < 4) ? floors[ph] : 30'($urandom()));
            for (int i = 0; i < 250; i++) begin
                send_sample(rand_rate(), rand_rate(), rand_rate(), rand_dt());
                // sender hold-off until everything is back
                if (i == 100) drain();
            end
        end
        drain();
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #100ms;
        $display("Verification failed");
        $finish;
    end
endmodule
